@@ hw/rtl/gss_pkg.sv @@
package gss_pkg;

  localparam int unsigned LFSR_W       = 31;
  localparam int unsigned WARMUP_STEPS = 1600;
  localparam int unsigned COUNT_W      = 11;
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [COUNT_W-1:0] WARM_LAST = COUNT_W'(WARMUP_STEPS - 1);

  // input item codes
  typedef enum logic [1:0] {
    MODE_RESTART = 2'd0,
    MODE_HARD    = 2'd1,
    MODE_SOFT    = 2'd2,
    MODE_UNUSED  = 2'd3
  } item_mode_t;

  // initial value forms
  typedef enum logic [1:0] {
    INIT_UL_SHARED = 2'd0,
    INIT_DL_SHARED = 2'd1,
    INIT_CONTROL   = 2'd2,
    INIT_UNUSED    = 2'd3
  } init_mode_t;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RNTI      = 2'd0,
    REG_CELL_ID   = 2'd1,
    REG_LAYER_Q   = 2'd2,
    REG_INIT_MODE = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic load_init;
    logic warm_step;
    logic data_hard;
    logic data_soft;
  } dp_cmd_t;

  typedef struct packed {
    logic warm_last;
    logic out_busy;
  } dp_status_t;

endpackage

@@ hw/rtl/gss_ctrl.sv @@
module gss_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          mode,
  input  gss_pkg::dp_status_t sts,
  output logic                in_stall,
  output gss_pkg::dp_cmd_t    cmd
);
  import gss_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_WARM
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state == ST_WARM) | sts.out_busy;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.warm_step = (state == ST_WARM);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item_mode_t'(mode))
            MODE_RESTART: begin
              cmd.load_init = 1'b1;
              state_next    = ST_WARM;
            end
            MODE_HARD: cmd.data_hard = 1'b1;
            MODE_SOFT: cmd.data_soft = 1'b1;
            default: ;
          endcase
        end
      end
      ST_WARM: begin
        if (sts.warm_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/gss_dp.sv @@
module gss_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gss_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gss_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  gss_pkg::dp_cmd_t                    cmd,
  input  logic                                hard_bit,
  input  logic signed [15:0]                  soft_value,
  input  logic                                out_stall,
  output gss_pkg::dp_status_t                 sts,
  output logic                                out_valid,
  output logic                                out_bit,
  output logic signed [15:0]                  out_soft,
  output logic                                seq_bit
);
  import gss_pkg::*;

  logic [15:0]         rnti;
  logic [9:0]          cell_id;
  logic                layer_q;
  logic [1:0]          init_mode;
  logic [LFSR_W-1:0]   x1;
  logic [LFSR_W-1:0]   x2;
  logic [LFSR_W-1:0]   x1_next;
  logic [LFSR_W-1:0]   x2_next;
  logic [LFSR_W-1:0]   cinit;
  logic [COUNT_W-1:0]  warmup_count;
  logic                seq;
  logic signed [15:0]  soft_next;

  // cell_id stays below 2^10, so the sums are plain concatenations
  always_comb begin
    case (init_mode_t'(init_mode))
      INIT_DL_SHARED: cinit = {rnti, layer_q, 4'b0, cell_id};
      INIT_CONTROL:   cinit = {rnti[14:0], 6'b0, cell_id};
      default:        cinit = {rnti, 5'b0, cell_id};
    endcase
  end

  assign seq     = x1[0] ^ x2[0];
  assign x1_next = {x1[3] ^ x1[0], x1[LFSR_W-1:1]};
  assign x2_next = {x2[3] ^ x2[2] ^ x2[1] ^ x2[0], x2[LFSR_W-1:1]};

  // negation of the most negative value saturates
  always_comb begin
    if (!seq) begin
      soft_next = soft_value;
    end else if (soft_value == 16'sh8000) begin
      soft_next = 16'sh7fff;
    end else begin
      soft_next = -soft_value;
    end
  end

  assign sts.warm_last = (warmup_count == WARM_LAST);
  assign sts.out_busy  = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rnti         <= '0;
      cell_id      <= '0;
      layer_q      <= 1'b0;
      init_mode    <= '0;
      x1           <= LFSR_W'(1);
      x2           <= '0;
      warmup_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_addr))
          REG_RNTI:      rnti      <= cfg_data;
          REG_CELL_ID:   cell_id   <= cfg_data[9:0];
          REG_LAYER_Q:   layer_q   <= cfg_data[0];
          REG_INIT_MODE: init_mode <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (cmd.load_init) begin
        x1           <= LFSR_W'(1);
        x2           <= cinit;
        warmup_count <= '0;
      end else if (cmd.warm_step) begin
        x1           <= x1_next;
        x2           <= x2_next;
        warmup_count <= warmup_count + COUNT_W'(1);
      end else if (cmd.data_hard | cmd.data_soft) begin
        x1 <= x1_next;
        x2 <= x2_next;
      end
      if (cmd.data_hard | cmd.data_soft) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.data_hard | cmd.data_soft) begin
      seq_bit  <= seq;
      out_bit  <= cmd.data_hard & (hard_bit ^ seq);
      out_soft <= cmd.data_soft ? soft_next : 16'sd0;
    end
  end

endmodule

@@ hw/rtl/gold_sequence_scrambler_top.sv @@
// length-31 gold sequence scrambler: a restart transaction (mode 0) forms
// c_init from rnti, cell_id, layer_q and init_mode, loads x1 = 1 and
// x2 = c_init, then advances both registers through 1600 discarded bits;
// in_stall is high during that warmup and no result is produced. hard
// (mode 1) and soft (mode 2) transactions are taken one per cycle unless
// the output is stalled: each uses the next sequence bit, advances the
// registers once and yields one result transaction in the next cycle
// from the output register. in_stall is also high while that output
// register holds a result that out_stall is blocking, so a transaction
// that meets a stalled receiver waits as long as out_stall stays high.
// mode 3 is dropped with no effect. data sent before any restart uses
// the reset registers (x1 = 1, x2 = 0) without warmup.
// configuration writes are expected only while the block is idle.
module gold_sequence_scrambler_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_write,
  input  logic [gss_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gss_pkg::CFG_DATA_W-1:0] cfg_data,
  // input transaction channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     mode,
  input  logic                           hard_bit,
  input  logic signed [15:0]             soft_value,
  // result transaction channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_bit,
  output logic signed [15:0]             out_soft,
  output logic                           seq_bit
);
  import gss_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  // sequencing: idle vs warmup, and acceptance of transactions
  gss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // config registers, both lfsrs, warmup counter and output register
  gss_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .hard_bit   (hard_bit),
    .soft_value (soft_value),
    .out_stall  (out_stall),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_bit    (out_bit),
    .out_soft   (out_soft),
    .seq_bit    (seq_bit)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import gss_pkg::*;

  // generous bound: restarts and drains dominate, far below this
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = WARMUP_STEPS + 16;
  localparam int TAIL_CYCLES  = 32;
  localparam int PHASE_ITEMS  = 440;

  // one predicted result transaction
  typedef struct packed {
    logic               out_bit;
    logic signed [15:0] out_soft;
    logic               seq_bit;
  } scramble_out_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            mode = MODE_HARD;
  logic                  hard_bit = 1'b0;
  logic signed [15:0]    soft_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_bit;
  logic signed [15:0]    out_soft;
  logic                  seq_bit;

  // mirror of the configuration registers
  logic [15:0]           rnti_m;
  logic [9:0]            cell_id_m;
  logic                  layer_q_m;
  init_mode_t            init_mode_m;

  // mirror of the two gold sequence shift registers
  logic [LFSR_W-1:0]     x1_m;
  logic [LFSR_W-1:0]     x2_m;

  scramble_out_t         pending_outputs[$];
  int                    fail_count = 0;
  int                    cycle_count = 0;

  // per-phase idling percentages
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;

  gold_sequence_scrambler_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .hard_bit   (hard_bit),
    .soft_value (soft_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_bit    (out_bit),
    .out_soft   (out_soft),
    .seq_bit    (seq_bit)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("gold_sequence_scrambler_top: mismatch");
      $finish;
    end
  end

  // current sequence bit, then one step of x1 and x2
  function automatic logic gold_advance();
    logic c;
    logic fa;
    logic fb;
    c    = x1_m[0] ^ x2_m[0];
    fa   = x1_m[3] ^ x1_m[0];
    fb   = x2_m[3] ^ x2_m[2] ^ x2_m[1] ^ x2_m[0];
    x1_m = {fa, x1_m[LFSR_W-1:1]};
    x2_m = {fb, x2_m[LFSR_W-1:1]};
    return c;
  endfunction

  // c_init from the mirrored registers, kept to 31 bits
  function automatic logic [LFSR_W-1:0] seed_value();
    logic [31:0] v;
    case (init_mode_m)
      INIT_CONTROL:   v = (32'(rnti_m) << 16) + 32'(cell_id_m);
      INIT_DL_SHARED: v = (32'(rnti_m) << 15) + (32'(layer_q_m) << 14) + 32'(cell_id_m);
      default:        v = (32'(rnti_m) << 15) + 32'(cell_id_m);
    endcase
    return v[LFSR_W-1:0];
  endfunction

  // predicted effect of one accepted input transaction
  function automatic void predict_scramble(item_mode_t m, logic hb, logic signed [15:0] sv);
    scramble_out_t r;
    logic          s;
    case (m)
      MODE_RESTART: begin
        x1_m = LFSR_W'(1);
        x2_m = seed_value();
        for (int i = 0; i < WARMUP_STEPS; i++) void'(gold_advance());
      end
      MODE_HARD: begin
        s          = gold_advance();
        r.out_bit  = hb ^ s;
        r.out_soft = '0;
        r.seq_bit  = s;
        pending_outputs.push_back(r);
      end
      MODE_SOFT: begin
        s          = gold_advance();
        r.out_bit  = 1'b0;
        // negation saturates at the most negative value
        if (!s)                   r.out_soft = sv;
        else if (sv == 16'sh8000) r.out_soft = 16'sh7fff;
        else                      r.out_soft = -sv;
        r.seq_bit  = s;
        pending_outputs.push_back(r);
      end
      default: ;  // unused mode is dropped with no effect
    endcase
  endfunction

  // monitor: config mirror, prediction on input accept, check on output accept
  always @(posedge clk) begin : monitor
    scramble_out_t got;
    scramble_out_t want;
    if (rst) begin
      rnti_m      = '0;
      cell_id_m   = '0;
      layer_q_m   = 1'b0;
      init_mode_m = INIT_UL_SHARED;
      x1_m        = LFSR_W'(1);
      x2_m        = '0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_addr))
          REG_RNTI:      rnti_m      = cfg_data[15:0];
          REG_CELL_ID:   cell_id_m   = cfg_data[9:0];
          REG_LAYER_Q:   layer_q_m   = cfg_data[0];
          REG_INIT_MODE: init_mode_m = init_mode_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_scramble(item_mode_t'(mode), hard_bit, soft_value);
      if (out_valid && !out_stall) begin
        got.out_bit  = out_bit;
        got.out_soft = out_soft;
        got.seq_bit  = seq_bit;
        if (pending_outputs.size() == 0) begin
          $display("%0t: result transaction expected none actual bit %0d soft %0d seq %0d",
                   $time, got.out_bit, got.out_soft, got.seq_bit);
          fail_count++;
        end else begin
          want = pending_outputs.pop_front();
          if (got.out_bit !== want.out_bit) begin
            $display("%0t: out_bit expected %0d actual %0d", $time, want.out_bit, got.out_bit);
            fail_count++;
          end
          if (got.out_soft !== want.out_soft) begin
            $display("%0t: out_soft expected %0d actual %0d", $time,
                     want.out_soft, got.out_soft);
            fail_count++;
          end
          if (got.seq_bit !== want.seq_bit) begin
            $display("%0t: seq_bit expected %0d actual %0d", $time, want.seq_bit, got.seq_bit);
            fail_count++;
          end
        end
      end
    end
  end

  // one register write, only called with the block idle
  task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(logic [15:0] rnti_v, logic [15:0] cell_v, logic [15:0] q_v,
                            logic [15:0] init_v);
    write_reg(REG_RNTI, rnti_v);
    write_reg(REG_CELL_ID, cell_v);
    write_reg(REG_LAYER_Q, q_v);
    write_reg(REG_INIT_MODE, init_v);
  endtask

  // random settings, extremes weighted up, junk above the field width sometimes
  task automatic random_config();
    logic [15:0] rnti_v;
    logic [15:0] cell_v;
    logic [15:0] q_v;
    logic [15:0] init_v;
    case ($urandom_range(0, 3))
      0:       rnti_v = 16'h0000;
      1:       rnti_v = 16'hffff;
      default: rnti_v = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       cell_v = 16'd0;
      1:       cell_v = 16'd1023;
      2:       cell_v = 16'($urandom);
      default: cell_v = 16'($urandom_range(0, 1023));
    endcase
    q_v    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1));
    init_v = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    set_config(rnti_v, cell_v, q_v, init_v);
  endtask

  // drop valid, wait out all results and any warmup still running
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one input transaction, with a random idle gap in front of it
  task automatic send_item(item_mode_t m, logic hb, logic signed [15:0] sv);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      gap++;
    end
    in_valid   <= 1'b1;
    mode       <= m;
    hard_bit   <= hb;
    soft_value <= sv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // random hard or soft data transaction, soft extremes weighted up
  task automatic send_data();
    logic signed [15:0] sv;
    case ($urandom_range(0, 11))
      0:       sv = 16'sh8000;
      1:       sv = 16'sh7fff;
      2:       sv = 16'sh0000;
      3:       sv = -16'sd1;
      default: sv = 16'($urandom);
    endcase
    send_item($urandom_range(0, 1) ? MODE_HARD : MODE_SOFT, 1'($urandom), sv);
  endtask

  // data with no restart runs from the reset registers
  task automatic test_unrestarted_stream();
    send_item(MODE_HARD, 1'b0, 16'sh1234);
    send_item(MODE_HARD, 1'b1, 16'sh0000);
    send_item(MODE_SOFT, 1'b1, 16'sh8000);
    send_item(MODE_SOFT, 1'b0, 16'sh7fff);
    drain_block();
  endtask

  // each c_init form at its extremes, unused codes and saturation
  task automatic test_init_forms();
    // control form overflows past 31 bits
    set_config(16'hffff, 16'd1023, 16'd1, INIT_CONTROL);
    send_item(MODE_RESTART, 1'b1, 16'sh7fff);
    send_item(MODE_SOFT, 1'b0, 16'sh8000);
    send_item(MODE_SOFT, 1'b1, 16'sh7fff);
    send_item(MODE_HARD, 1'b1, 16'sh8000);
    // unused mode must leave the sequence alone
    send_item(MODE_UNUSED, 1'b1, 16'sh8000);
    send_item(MODE_HARD, 1'b0, 16'sh0000);
    send_item(MODE_SOFT, 1'b0, 16'sh8000);
    drain_block();
    // downlink form with q set
    set_config(16'hffff, 16'd1023, 16'd1, INIT_DL_SHARED);
    send_item(MODE_RESTART, 1'b0, 16'sh0000);
    send_item(MODE_SOFT, 1'b0, 16'sh8000);
    send_item(MODE_HARD, 1'b1, -16'sd1);
    drain_block();
    // unused init form behaves as uplink
    set_config(16'h8001, 16'd512, 16'd1, INIT_UNUSED);
    send_item(MODE_RESTART, 1'b0, 16'sh0000);
    send_item(MODE_SOFT, 1'b0, -16'sd1);
    send_item(MODE_HARD, 1'b0, 16'sh0001);
    drain_block();
    // uplink form, all-zero seed
    set_config(16'h0000, 16'd0, 16'd0, INIT_UL_SHARED);
    send_item(MODE_RESTART, 1'b0, 16'sh0000);
    send_item(MODE_SOFT, 1'b1, 16'sh8000);
    send_item(MODE_HARD, 1'b1, 16'sh0000);
    drain_block();
  endtask

  // mostly restart-then-burst sequences, some noise and broken sequences
  task automatic test_scramble_stream(int n_items, int idle_pct, int stall_p);
    int sent;
    int seq_no;
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    sent          = 0;
    seq_no        = 0;
    drain_block();
    random_config();
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        8: begin
          // noise: unused codes and data with no fresh restart
          repeat ($urandom_range(1, 4)) send_item(MODE_UNUSED, 1'($urandom), 16'($urandom));
          repeat ($urandom_range(1, 10)) begin
            send_data();
            sent++;
          end
        end
        9: begin
          // broken: restart with no data, maybe restarted again at once
          send_item(MODE_RESTART, 1'($urandom), 16'($urandom));
          sent++;
          if ($urandom_range(0, 1)) begin
            send_item(MODE_RESTART, 1'($urandom), 16'($urandom));
            sent++;
          end
        end
        default: begin
          send_item(MODE_RESTART, 1'($urandom), 16'($urandom));
          sent++;
          repeat ($urandom_range(4, 60)) begin
            send_data();
            sent++;
          end
        end
      endcase
      seq_no++;
      // new settings every few sequences
      if (seq_no % 5 == 0) begin
        drain_block();
        random_config();
      end
    end
    drain_block();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_unrestarted_stream();
    test_init_forms();
    // idling phases: none, sender, receiver, both
    test_scramble_stream(PHASE_ITEMS, 0, 0);
    test_scramble_stream(PHASE_ITEMS, 68, 0);
    test_scramble_stream(PHASE_ITEMS, 0, 68);
    test_scramble_stream(PHASE_ITEMS, 36, 36);
    stall_pct = 0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("gold_sequence_scrambler_top: match");
    end else begin
      $display("gold_sequence_scrambler_top: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/gss_pkg.sv
hw/rtl/gss_ctrl.sv
hw/rtl/gss_dp.sv
hw/rtl/gold_sequence_scrambler_top.sv
dv/tb.sv
